// File: rtl/core/multilevel_queue_scheduler_unit_macros.svh
// Assertion macros used by the scheduler's checker file.
`ifndef MULTILEVEL_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define MLQS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define MLQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mlqs_pkg.sv
// Types and constants of the multilevel queue scheduler.
`default_nettype none
package mlqs_pkg;

  localparam int MAX_LEVELS = 3;
  localparam int LEVEL_W    = 2;
  localparam int ID_W       = 8;
  localparam int DATA_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int REG_IDX_W  = 3;

  localparam logic OP_ARRIVAL  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ADMITTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJ_CLASS = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJ_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_IDLE      = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_CLASS_FLOOR    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL0_UPPER   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL1_UPPER   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL2_UPPER   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL0_QUANTUM = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL1_QUANTUM = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL2_QUANTUM = 3'd6;

  localparam logic [DATA_W-1:0] CLASS_FLOOR_RST    = 16'd0;
  localparam logic [DATA_W-1:0] LEVEL0_UPPER_RST   = 16'd4;
  localparam logic [DATA_W-1:0] LEVEL1_UPPER_RST   = 16'd16;
  localparam logic [DATA_W-1:0] LEVEL2_UPPER_RST   = 16'd65535;
  localparam logic [DATA_W-1:0] LEVEL0_QUANTUM_RST = 16'd2;
  localparam logic [DATA_W-1:0] LEVEL1_QUANTUM_RST = 16'd4;
  localparam logic [DATA_W-1:0] LEVEL2_QUANTUM_RST = 16'd8;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] demand;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic [LEVEL_W-1:0] lv;
  } class_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     granted_id;
    logic [LEVEL_W-1:0]  level;
    logic [DATA_W-1:0]   slice;
    logic [DATA_W-1:0]   left_over;
    logic                finished;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/mlqs_req_if.sv
// Request channel of the scheduler: task arrivals and dispatch requests.
`default_nettype none
interface mlqs_req_if;
  import mlqs_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ID_W-1:0]   task_id;
  logic [DATA_W-1:0] demand;
  modport source (output valid, output opcode, output task_id, output demand, input ready);
  modport sink (input valid, input opcode, input task_id, input demand, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mlqs_rsp_if.sv
// Response channel of the scheduler: one result per request.
`default_nettype none
interface mlqs_rsp_if;
  import mlqs_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     granted_id;
  logic [LEVEL_W-1:0]  level;
  logic [DATA_W-1:0]   slice;
  logic [DATA_W-1:0]   left_over;
  logic                finished;
  modport source (output valid, output status, output granted_id, output level,
                  output slice, output left_over, output finished, input ready);
  modport sink (input valid, input status, input granted_id, input level,
                input slice, input left_over, input finished, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mlqs_classify.sv
// Demand classifier: maps a demand onto the highest-priority matching level.
`default_nettype none
module mlqs_classify #(
  parameter int NUM_LEVELS = 3
) (
  input  logic [mlqs_pkg::DATA_W-1:0] demand,
  input  logic [mlqs_pkg::DATA_W-1:0] class_floor,
  input  logic [mlqs_pkg::DATA_W-1:0] upper [mlqs_pkg::MAX_LEVELS],
  output mlqs_pkg::class_t            cls
);
  import mlqs_pkg::*;

  always_comb begin
    logic [DATA_W-1:0] lower;
    lower = class_floor;
    cls   = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (!cls.hit && demand != '0 && demand > lower && demand <= upper[l]) begin
        cls.hit = 1'b1;
        cls.lv  = LEVEL_W'(l);
      end
      lower = upper[l];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mlqs_store.sv
// Level store: one-port-write, one-port-read memory with registered read data.
`default_nettype none
module mlqs_store #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] wr_q;
  logic             fwd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
      wr_q <= wdata;
      fwd  <= we && (waddr == raddr);
    end
  end

  // A read of the entry written in the same cycle returns the new data.
  assign rdata = fwd ? wr_q : rd_q;

endmodule
`default_nettype wire

// File: rtl/core/multilevel_queue_scheduler_unit.sv
// Multilevel queue scheduler with round robin inside each level: top level.
// Requests are taken one at a time. An arrival is classed, checked and written
// to the level store in the cycle it is accepted; its result is ready in the
// cycle after the transfer. A dispatch puts the preempted task back and reads
// the chosen head from the level store, whose read data is registered; its
// result is formed from that data in S_READ and then registered. A new request
// is taken once the previous result has moved to the output register. A
// stalled output holds the following result, and with it further requests,
// until the waiting result is taken. The store needs no clearing after reset;
// only entries written by an enqueue are ever used.
`default_nettype none
module multilevel_queue_scheduler_unit #(
  parameter int LEVEL_DEPTH = 16,
  parameter int NUM_LEVELS  = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  mlqs_req_if.sink                       req,
  mlqs_rsp_if.source                     rsp,
  input  logic                           cfg_write,
  input  logic [mlqs_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mlqs_pkg::DATA_W-1:0]    cfg_data
);
  import mlqs_pkg::*;

  localparam int HW    = $clog2(LEVEL_DEPTH);
  localparam int CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  function automatic logic [HW-1:0] tail_pos(input logic [HW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(c);
    if (sum >= (CW+1)'(LEVEL_DEPTH)) begin
      sum = sum - (CW+1)'(LEVEL_DEPTH);
    end
    return sum[HW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [LEVEL_W-1:0] lv,
                                               input logic [HW-1:0] pos);
    return AW'(lv) * AW'(LEVEL_DEPTH) + AW'(pos);
  endfunction

  logic [1:0]         state;
  logic [DATA_W-1:0]  class_floor;
  logic [DATA_W-1:0]  upper [MAX_LEVELS];
  logic [DATA_W-1:0]  quantum [MAX_LEVELS];
  logic [HW-1:0]      head [NUM_LEVELS];
  logic [CW-1:0]      count [NUM_LEVELS];
  logic               pend_valid;
  logic [LEVEL_W-1:0] pend_lv;
  entry_t             pend_entry;
  logic               d_found;
  logic [LEVEL_W-1:0] d_lv;
  result_t            res;
  logic               rsp_valid;
  result_t            rsp_data;

  class_t             cls;
  logic               accept;
  logic               is_disp;
  logic [CW-1:0]      arr_cnt;
  logic [CW:0]        arr_used;
  logic               arr_full;
  logic [CW-1:0]      pend_cnt;
  logic               pput;
  logic [LEVEL_W-1:0] wlv;
  logic [HW-1:0]      w_head;
  logic [CW-1:0]      w_cnt;
  logic               mem_we;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_waddr;
  logic [CW-1:0]      cnt_after [NUM_LEVELS];
  logic               found;
  logic [LEVEL_W-1:0] sel;
  logic [HW-1:0]      sel_head;
  logic [AW-1:0]      mem_raddr;
  entry_t             rd_entry;
  logic [DATA_W-1:0]  d_quantum;
  logic [DATA_W-1:0]  d_slice;
  logic [DATA_W-1:0]  d_left;
  result_t            arr_res;
  result_t            disp_res;

  mlqs_classify #(.NUM_LEVELS(NUM_LEVELS)) u_classify (
    .demand      (req.demand),
    .class_floor (class_floor),
    .upper       (upper),
    .cls         (cls)
  );

  mlqs_store #(.DEPTH(SLOTS), .WIDTH($bits(entry_t))) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_disp   = (req.opcode == OP_DISPATCH);

  always_comb begin
    arr_cnt  = '0;
    pend_cnt = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (LEVEL_W'(l) == cls.lv) begin
        arr_cnt = count[l];
      end
      if (LEVEL_W'(l) == pend_lv) begin
        pend_cnt = count[l];
      end
    end
    arr_used = (CW+1)'(arr_cnt) + (CW+1)'(pend_valid && pend_lv == cls.lv);
    arr_full = arr_used >= (CW+1)'(LEVEL_DEPTH);
    pput     = pend_valid && (32'(pend_lv) < NUM_LEVELS) &&
               (32'(pend_cnt) < LEVEL_DEPTH);

    wlv       = is_disp ? pend_lv : cls.lv;
    mem_wdata = is_disp ? pend_entry : entry_t'({req.task_id, req.demand});
    mem_we    = accept && (is_disp ? pput : (cls.hit && !arr_full));
    w_head    = '0;
    w_cnt     = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (LEVEL_W'(l) == wlv) begin
        w_head = head[l];
        w_cnt  = count[l];
      end
    end
    mem_waddr = slot_addr(wlv, tail_pos(w_head, w_cnt));

    found = 1'b0;
    sel   = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      cnt_after[l] = count[l] + CW'(pput && pend_lv == LEVEL_W'(l));
      if (cnt_after[l] != '0) begin
        found = 1'b1;
        sel   = LEVEL_W'(l);
      end
    end
    sel_head = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (LEVEL_W'(l) == sel) begin
        sel_head = head[l];
      end
    end
    mem_raddr = slot_addr(sel, sel_head);

    arr_res            = '0;
    arr_res.granted_id = req.task_id;
    if (!cls.hit) begin
      arr_res.status = STATUS_REJ_CLASS;
    end else begin
      arr_res.level  = cls.lv;
      arr_res.status = arr_full ? STATUS_REJ_FULL : STATUS_ADMITTED;
    end

    d_quantum = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (LEVEL_W'(l) == d_lv) begin
        d_quantum = quantum[l];
      end
    end
    d_slice = (rd_entry.demand < d_quantum) ? rd_entry.demand : d_quantum;
    d_left  = rd_entry.demand - d_slice;

    disp_res = '0;
    if (d_found) begin
      disp_res.status     = STATUS_GRANTED;
      disp_res.granted_id = rd_entry.id;
      disp_res.level      = d_lv;
      disp_res.slice      = d_slice;
      disp_res.left_over  = d_left;
      disp_res.finished   = (d_left == '0);
    end else begin
      disp_res.status = STATUS_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class_floor <= CLASS_FLOOR_RST;
      upper[0]    <= LEVEL0_UPPER_RST;
      upper[1]    <= LEVEL1_UPPER_RST;
      upper[2]    <= LEVEL2_UPPER_RST;
      quantum[0]  <= LEVEL0_QUANTUM_RST;
      quantum[1]  <= LEVEL1_QUANTUM_RST;
      quantum[2]  <= LEVEL2_QUANTUM_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CLASS_FLOOR:    class_floor <= cfg_data;
        REG_LEVEL0_UPPER:   upper[0]    <= cfg_data;
        REG_LEVEL1_UPPER:   upper[1]    <= cfg_data;
        REG_LEVEL2_UPPER:   upper[2]    <= cfg_data;
        REG_LEVEL0_QUANTUM: quantum[0]  <= cfg_data;
        REG_LEVEL1_QUANTUM: quantum[1]  <= cfg_data;
        REG_LEVEL2_QUANTUM: quantum[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      d_found    <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= '0;
        count[l] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_disp) begin
              for (int l = 0; l < NUM_LEVELS; l++) begin
                count[l] <= cnt_after[l] - CW'(found && sel == LEVEL_W'(l));
                if (found && sel == LEVEL_W'(l)) begin
                  head[l] <= (32'(head[l]) == LEVEL_DEPTH - 1) ? '0 : head[l] + 1'b1;
                end
              end
              pend_valid <= 1'b0;
              d_found    <= found;
              d_lv       <= sel;
              state      <= S_READ;
            end else begin
              for (int l = 0; l < NUM_LEVELS; l++) begin
                if (mem_we && cls.lv == LEVEL_W'(l)) begin
                  count[l] <= count[l] + 1'b1;
                end
              end
              res   <= arr_res;
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          res <= disp_res;
          if (d_found && d_left != '0) begin
            pend_valid <= 1'b1;
            pend_lv    <= d_lv;
            pend_entry <= entry_t'({rd_entry.id, d_left});
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
        rsp_data  <= res;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_data.status;
  assign rsp.granted_id = rsp_data.granted_id;
  assign rsp.level      = rsp_data.level;
  assign rsp.slice      = rsp_data.slice;
  assign rsp.left_over  = rsp_data.left_over;
  assign rsp.finished   = rsp_data.finished;

endmodule
`default_nettype wire

// File: rtl/core/mlqs_checker.sv
// Port-level checker of the scheduler and its bind to the top level.
`default_nettype none
`include "multilevel_queue_scheduler_unit_macros.svh"
module mlqs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [mlqs_pkg::STATUS_W-1:0]  status,
  input logic [mlqs_pkg::ID_W-1:0]      granted_id,
  input logic [mlqs_pkg::LEVEL_W-1:0]   level,
  input logic [mlqs_pkg::DATA_W-1:0]    slice,
  input logic [mlqs_pkg::DATA_W-1:0]    left_over,
  input logic                           finished
);
  import mlqs_pkg::*;

  `MLQS_ASSERT_NEXT(a_busy_after_transfer, req_valid && req_ready, !req_ready, "request taken while busy")
  `MLQS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(granted_id) && $stable(slice) && $stable(left_over), "stalled response changed")
  `MLQS_ASSERT_IMPL(a_grant_finish, rsp_valid && status == STATUS_GRANTED, finished == (left_over == '0), "finished flag disagrees with remaining demand")
  `MLQS_ASSERT_IMPL(a_idle_zero, rsp_valid && status == STATUS_IDLE, granted_id == '0 && level == '0 && slice == '0 && left_over == '0 && !finished, "idle result carries data")

endmodule

bind multilevel_queue_scheduler_unit mlqs_checker u_mlqs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .granted_id (rsp.granted_id),
  .level      (rsp.level),
  .slice      (rsp.slice),
  .left_over  (rsp.left_over),
  .finished   (rsp.finished)
);
`default_nettype wire

// File: bench/tb_top.sv
// Testbench of the multilevel queue scheduler: directed and random traffic against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import mlqs_pkg::*;

  localparam int LEVEL_DEPTH    = 16;
  localparam int NUM_LEVELS     = 3;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 100;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_pattern_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 rx_ready = 1'b0;

  mlqs_req_if req_ch ();
  mlqs_rsp_if rsp_ch ();

  assign rsp_ch.ready = rx_ready;

  multilevel_queue_scheduler_unit #(
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow of the scheduler: registers, per-level queues and the preempted task.
  logic [DATA_W-1:0] sched_regs [7] = '{CLASS_FLOOR_RST, LEVEL0_UPPER_RST, LEVEL1_UPPER_RST,
                                        LEVEL2_UPPER_RST, LEVEL0_QUANTUM_RST,
                                        LEVEL1_QUANTUM_RST, LEVEL2_QUANTUM_RST};
  entry_t            level_fifo [NUM_LEVELS][$];
  logic              preempted_valid = 1'b0;
  int                preempted_level = 0;
  entry_t            preempted_task = '0;

  result_t           due_results [$];
  int                fails = 0;
  int                sent_items = 0;
  int                burst_left = 0;
  int                stuck_cycles = 0;
  rx_pattern_e       rx_pattern = RX_ALWAYS;
  int                rx_segment = 0;
  int                rx_tick = 0;

  function automatic class_t classify_demand(logic [DATA_W-1:0] dem);
    class_t            c;
    logic [DATA_W-1:0] lower;
    c = '0;
    if (dem == 0) return c;
    lower = sched_regs[REG_CLASS_FLOOR];
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      if (dem > lower && dem <= sched_regs[REG_LEVEL0_UPPER + lv]) begin
        c.hit = 1'b1;
        c.lv = LEVEL_W'(lv);
        return c;
      end
      lower = sched_regs[REG_LEVEL0_UPPER + lv];
    end
    return c;
  endfunction

  function automatic result_t schedule_item(logic op, logic [ID_W-1:0] id,
                                            logic [DATA_W-1:0] dem);
    result_t           r;
    class_t            cls;
    entry_t            e;
    int                used;
    logic [DATA_W-1:0] q;
    r = '0;
    if (op == OP_ARRIVAL) begin
      r.granted_id = id;
      cls = classify_demand(dem);
      if (!cls.hit) begin
        r.status = STATUS_REJ_CLASS;
        return r;
      end
      r.level = cls.lv;
      used = level_fifo[cls.lv].size();
      if (preempted_valid && preempted_level == cls.lv) used++;
      if (used >= LEVEL_DEPTH) begin
        r.status = STATUS_REJ_FULL;
      end else begin
        e.id = id;
        e.demand = dem;
        level_fifo[cls.lv].push_back(e);
        r.status = STATUS_ADMITTED;
      end
      return r;
    end
    if (preempted_valid) begin
      if (level_fifo[preempted_level].size() < LEVEL_DEPTH)
        level_fifo[preempted_level].push_back(preempted_task);
      preempted_valid = 1'b0;
    end
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      if (level_fifo[lv].size() != 0) begin
        e = level_fifo[lv].pop_front();
        q = sched_regs[REG_LEVEL0_QUANTUM + lv];
        r.status = STATUS_GRANTED;
        r.granted_id = e.id;
        r.level = LEVEL_W'(lv);
        r.slice = (e.demand < q) ? e.demand : q;
        r.left_over = e.demand - r.slice;
        r.finished = (r.left_over == 0);
        if (r.left_over != 0) begin
          preempted_valid = 1'b1;
          preempted_level = lv;
          preempted_task.id = e.id;
          preempted_task.demand = r.left_over;
        end
        return r;
      end
    end
    r.status = STATUS_IDLE;
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                           input logic [DATA_W-1:0] dem);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_ch.valid   <= 1'b1;
    req_ch.opcode  <= op;
    req_ch.task_id <= id;
    req_ch.demand  <= dem;
    do @(posedge clk); while (!req_ch.ready);
    due_results.push_back(schedule_item(op, id, dem));
    sent_items++;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic program_regs(input logic [DATA_W-1:0] floor_v, u0, u1, u2, q0, q1, q2);
    logic [DATA_W-1:0] vals [7];
    vals = '{floor_v, u0, u1, u2, q0, q1, q2};
    for (int i = REG_CLASS_FLOOR; i <= REG_LEVEL2_QUANTUM; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sched_regs[i] = vals[i];
    end
    cfg_index <= REG_UNUSED;
    cfg_data  <= DATA_W'($urandom_range(0, 65535));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] level_demand(int lv);
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int                span;
    lo = (lv == 0) ? sched_regs[REG_CLASS_FLOOR] : sched_regs[REG_LEVEL0_UPPER + lv - 1];
    hi = sched_regs[REG_LEVEL0_UPPER + lv];
    if (hi <= lo) return DATA_W'($urandom_range(0, 65535));
    span = hi - lo;
    if (span > 64 && $urandom_range(0, 3) != 0) span = 64;
    return lo + DATA_W'($urandom_range(1, span));
  endfunction

  function automatic logic [DATA_W-1:0] pick_demand();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 12) return DATA_W'($urandom_range(0, 65535));
    if (sel < 17) return sched_regs[REG_LEVEL2_UPPER] + 16'd1;
    return level_demand($urandom_range(0, NUM_LEVELS - 1));
  endfunction

  task automatic send_random(input int arrive_pct);
    if ($urandom_range(0, 99) < arrive_pct)
      send_item(OP_ARRIVAL, ID_W'($urandom_range(0, 255)), pick_demand());
    else
      send_item(OP_DISPATCH, ID_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 65535)));
  endtask

  task automatic randomize_regs();
    logic [DATA_W-1:0] fl, u0, u1, u2, q0, q1, q2;
    int                shape;
    shape = $urandom_range(0, 7);
    if (shape == 0) begin
      // Unordered bounds, so classes overlap or vanish; a quantum may be zero.
      fl = DATA_W'($urandom_range(0, 50));
      u0 = DATA_W'($urandom_range(0, 300));
      u1 = DATA_W'($urandom_range(0, 300));
      u2 = DATA_W'($urandom_range(0, 300));
      q0 = DATA_W'($urandom_range(0, 6));
      q1 = DATA_W'($urandom_range(0, 6));
      q2 = DATA_W'($urandom_range(0, 6));
    end else begin
      fl = DATA_W'($urandom_range(0, 4));
      u0 = fl + DATA_W'($urandom_range(1, 8));
      u1 = u0 + DATA_W'($urandom_range(1, 32));
      u2 = (shape == 1) ? 16'hFFFF : u1 + DATA_W'($urandom_range(1, 200));
      q0 = DATA_W'($urandom_range(1, 6));
      q1 = DATA_W'($urandom_range(1, 12));
      q2 = (shape == 2) ? 16'hFFFF : DATA_W'($urandom_range(1, 40));
    end
    program_regs(fl, u0, u1, u2, q0, q1, q2);
  endtask

  task automatic test_basic_flow();
    send_item(OP_DISPATCH, 8'hA5, 16'h5A5A);
    send_item(OP_ARRIVAL, 8'h00, 16'h0000);
    send_item(OP_ARRIVAL, 8'hFF, 16'hFFFF);
    send_item(OP_ARRIVAL, 8'h01, 16'd1);
    send_item(OP_ARRIVAL, 8'h10, 16'd16);
    send_item(OP_ARRIVAL, 8'h11, 16'd5);
    repeat (5) send_item(OP_DISPATCH, 8'h5A, 16'hA5A5);
  endtask

  task automatic test_overlapping_bounds();
    drain_results();
    program_regs(16'd0, 16'd20, 16'd10, 16'd30, 16'd3, 16'd3, 16'd3);
    send_item(OP_ARRIVAL, 8'h21, 16'd15);
    send_item(OP_ARRIVAL, 8'h22, 16'd25);
    send_item(OP_ARRIVAL, 8'h23, 16'd31);
    drain_results();
    program_regs(16'd10, 16'd5, 16'd20, 16'd40, 16'd3, 16'd3, 16'd3);
    send_item(OP_ARRIVAL, 8'h24, 16'd7);
    send_item(OP_ARRIVAL, 8'h25, 16'd3);
  endtask

  task automatic test_zero_quantum();
    drain_results();
    program_regs(16'd0, 16'd4, 16'd16, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    send_item(OP_ARRIVAL, 8'h31, 16'd2);
    repeat (2) send_item(OP_DISPATCH, 8'h00, 16'h0000);
  endtask

  task automatic test_register_extremes();
    drain_results();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
    send_item(OP_ARRIVAL, 8'h41, 16'hFFFF);
    send_item(OP_ARRIVAL, 8'h42, 16'd1);
    drain_results();
    program_regs(16'd0, 16'd1, 16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_ARRIVAL, 8'h43, 16'd2);
    repeat (3) send_item(OP_DISPATCH, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_random_traffic();
    int start;
    int kind;
    int lv;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      if (phase == 0)
        program_regs(CLASS_FLOOR_RST, LEVEL0_UPPER_RST, LEVEL1_UPPER_RST, LEVEL2_UPPER_RST,
                     LEVEL0_QUANTUM_RST, LEVEL1_QUANTUM_RST, LEVEL2_QUANTUM_RST);
      else
        randomize_regs();
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) begin
        kind = $urandom_range(0, 3);
        if (kind == 0) begin
          // Flood one level with arrivals, which may fill it, then probe the preempted slot.
          lv = $urandom_range(0, NUM_LEVELS - 1);
          repeat ($urandom_range(10, 20))
            send_item(OP_ARRIVAL, ID_W'($urandom_range(0, 255)), level_demand(lv));
          send_item(OP_DISPATCH, ID_W'($urandom_range(0, 255)),
                    DATA_W'($urandom_range(0, 65535)));
          repeat (2)
            send_item(OP_ARRIVAL, ID_W'($urandom_range(0, 255)), level_demand(lv));
        end else if (kind == 1) begin
          repeat ($urandom_range(5, 30))
            send_item(OP_DISPATCH, ID_W'($urandom_range(0, 255)),
                      DATA_W'($urandom_range(0, 65535)));
        end else begin
          repeat (30) send_random($urandom_range(20, 80));
        end
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: status %0d id %0d",
               rsp_ch.status, rsp_ch.granted_id);
        fails++;
      end else begin
        want = due_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(rsp_ch.status));
        check_field("granted_id", DATA_W'(want.granted_id), DATA_W'(rsp_ch.granted_id));
        check_field("level", DATA_W'(want.level), DATA_W'(rsp_ch.level));
        check_field("slice", want.slice, rsp_ch.slice);
        check_field("left_over", want.left_over, rsp_ch.left_over);
        check_field("finished", DATA_W'(want.finished), DATA_W'(rsp_ch.finished));
      end
    end
  end

  always @(posedge clk) begin
    if (rx_segment == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_segment = $urandom_range(20, 150);
    end
    rx_segment--;
    rx_tick++;
    case (rx_pattern)
      RX_ALWAYS: begin
        rx_ready <= 1'b1;
      end
      RX_RANDOM: begin
        rx_ready <= 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        rx_ready <= (rx_tick % 5) != 0;
      end
      default: begin
        rx_ready <= (rx_tick % 16) >= 12;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid   <= 1'b0;
    req_ch.opcode  <= OP_ARRIVAL;
    req_ch.task_id <= '0;
    req_ch.demand  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basic_flow();
    test_overlapping_bounds();
    test_zero_quantum();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
